[rtl/core/nha_pkg.sv]
package nha_pkg;

    localparam int DEF_MAX_KAPPA_HALF = 64;
    localparam int DEF_MAX_PSI_BINS   = 128;
    localparam int DEF_COUNT_WIDTH    = 32;

    // configuration register indexes
    localparam logic [2:0] CFG_KAPPA_HALF = 3'd0;
    localparam logic [2:0] CFG_PSI_COUNT  = 3'd1;
    localparam logic [2:0] CFG_PSI_MIN    = 3'd2;
    localparam logic [2:0] CFG_PSI_MAX    = 3'd3;
    localparam logic [2:0] CFG_PSI_SCALE  = 3'd4;

    localparam logic [6:0] RST_KAPPA_HALF = 7'd64;
    localparam logic [7:0] RST_PSI_COUNT  = 8'd128;

    // item modes
    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] kappa;
        logic signed [31:0] psi;
        logic signed [15:0] weight;
        logic [5:0]         table_index;
        logic [30:0]        table_value;
        logic [14:0]        cell_index;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic [7:0]         kappa_bin;
        logic [7:0]         psi_bin;
        logic [14:0]        cell_address;
        logic signed [31:0] content;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADDR,
        ST_CRD,
        ST_CMOD,
        ST_DONE
    } state_t;

endpackage

[rtl/core/nonuniform_histogram_accumulator_unit.sv]
// Hough accumulator histogram with non-uniform kappa bins and uniform psi bins.
// Input channel in_valid/in_stall/in_data carries one item: fill, boundary load,
// cell read or cell read-and-clear. Output channel out_valid/out_stall/out_data
// returns exactly one result per item, in order.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the five
// registers; cfg_ready is always high. Write only while the block is idle.
// Items are processed one at a time; out_valid rises as the block returns to
// idle and can take the next item. Steps per mode:
//   fill        scan of kappa_half_bins (clamped to 2..MAX_KAPPA_HALF) entries
//               (boundary table scanned one entry per cycle through its single
//               read port, then one read-modify-write of the cell store)
//   load        table write only; read / read-clear one access of the cell store
// After reset the cell store is zeroed by a clearing pass over all
// (MAX_PSI_BINS+2)*(2*MAX_KAPPA_HALF+2) cells (16900 by default); in_stall
// stays high during it. Config writes are taken during the pass.
// A finished result sits in the output register; the next item is taken and
// processed while it waits, and holds in its last step until the receiver
// drops out_stall.
module nonuniform_histogram_accumulator_unit #(
    parameter int MAX_KAPPA_HALF = nha_pkg::DEF_MAX_KAPPA_HALF,
    parameter int MAX_PSI_BINS   = nha_pkg::DEF_MAX_PSI_BINS,
    parameter int COUNT_WIDTH    = nha_pkg::DEF_COUNT_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  nha_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output nha_pkg::out_t out_data,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int STRIDE_MAX = 2 * MAX_KAPPA_HALF + 2;
    localparam int DEPTH      = (MAX_PSI_BINS + 2) * STRIDE_MAX;
    localparam int AW         = $clog2(DEPTH);
    localparam int BW         = $clog2(MAX_KAPPA_HALF);
    localparam int HW         = $clog2(MAX_KAPPA_HALF + 1);
    localparam int PW         = $clog2(MAX_PSI_BINS + 2);

    // configuration registers
    logic [6:0]         khalf_reg;
    logic [7:0]         pcount_reg;
    logic signed [31:0] pmin_reg, pmax_reg;
    logic [31:0]        pscale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            khalf_reg  <= nha_pkg::RST_KAPPA_HALF;
            pcount_reg <= nha_pkg::RST_PSI_COUNT;
            pmin_reg   <= '0;
            pmax_reg   <= '0;
            pscale_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nha_pkg::CFG_KAPPA_HALF: khalf_reg  <= cfg_data[6:0];
                nha_pkg::CFG_PSI_COUNT:  pcount_reg <= cfg_data[7:0];
                nha_pkg::CFG_PSI_MIN:    pmin_reg   <= cfg_data;
                nha_pkg::CFG_PSI_MAX:    pmax_reg   <= cfg_data;
                nha_pkg::CFG_PSI_SCALE:  pscale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped counts
    logic [HW-1:0] half;
    logic [PW-1:0] pcount;

    always_comb
    begin
        if (khalf_reg < 7'd2)
        begin
            half = HW'(2);
        end
        else if (32'(khalf_reg) > MAX_KAPPA_HALF)
        begin
            half = HW'(MAX_KAPPA_HALF);
        end
        else
        begin
            half = HW'(khalf_reg);
        end
        if (pcount_reg == 8'd0)
        begin
            pcount = PW'(1);
        end
        else if (32'(pcount_reg) > MAX_PSI_BINS)
        begin
            pcount = PW'(MAX_PSI_BINS);
        end
        else
        begin
            pcount = PW'(pcount_reg);
        end
    end

    nha_pkg::state_t state_reg, state_next;
    nha_pkg::in_t    item_reg;
    nha_pkg::out_t   res_reg, out_reg;
    logic            out_valid_reg;
    logic [31:0]     mag_reg;
    logic [30:0]     b0_reg, prev_reg;
    logic            found_reg, rej_reg;
    logic [BW-1:0]   j_reg, b_reg;
    logic [AW-1:0]   caddr_reg;

    logic in_xfer, out_free, clr_busy;
    logic load_ok, cell_ok, scan_last, hit_now, fill_ok;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_ok  = 32'(in_data.table_index) < MAX_KAPPA_HALF;
    assign cell_ok  = 32'(in_data.cell_index) < DEPTH;

    // memories and psi unit
    logic [BW-1:0]          b_rd_addr;
    logic [30:0]            b_rd_data;
    logic                   b_wr_en;
    logic [AW-1:0]          c_rd_addr;
    logic [COUNT_WIDTH-1:0] c_rd_data, c_wr_data;
    logic                   c_wr_en;
    logic [19:0]            psi_quot;
    logic                   psi_ok;

    nha_bound_mem #(.DEPTH(MAX_KAPPA_HALF)) u_bound (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (BW'(in_data.table_index)),
        .wr_data (in_data.table_value),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    nha_cell_mem #(.DEPTH(DEPTH), .DW(COUNT_WIDTH)) u_cells (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (c_wr_en),
        .wr_addr (caddr_reg),
        .wr_data (c_wr_data),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data),
        .busy    (clr_busy)
    );

    nha_psi_unit u_psi (
        .clk       (clk),
        .psi       (item_reg.psi),
        .psi_min   (pmin_reg),
        .psi_max   (pmax_reg),
        .psi_scale (pscale_reg),
        .quot      (psi_quot),
        .in_range  (psi_ok)
    );

    // scan: b_rd_data holds B[j_reg], prev_reg holds B[j_reg-1]
    assign scan_last = 32'(j_reg) == 32'(half) - 1;
    assign hit_now   = (j_reg != '0) && (mag_reg <= 32'(prev_reg))
                       && (mag_reg > 32'(b_rd_data));
    assign fill_ok   = !rej_reg && psi_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nha_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.mode == nha_pkg::MODE_FILL)
                    begin
                        state_next = nha_pkg::ST_SCAN;
                    end
                    else if (in_data.mode == nha_pkg::MODE_LOAD || !cell_ok)
                    begin
                        state_next = nha_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = nha_pkg::ST_CRD;
                    end
                end
            end
            nha_pkg::ST_SCAN: if (scan_last) state_next = nha_pkg::ST_ADDR;
            nha_pkg::ST_ADDR: state_next = fill_ok ? nha_pkg::ST_CRD : nha_pkg::ST_DONE;
            nha_pkg::ST_CRD:  state_next = nha_pkg::ST_CMOD;
            nha_pkg::ST_CMOD: state_next = nha_pkg::ST_DONE;
            nha_pkg::ST_DONE: if (out_free) state_next = nha_pkg::ST_IDLE;
            default:          state_next = nha_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    logic [COUNT_WIDTH-1:0] sum;
    logic signed [31:0]     w32;

    assign w32 = 32'(item_reg.weight);
    assign sum = c_rd_data + w32[COUNT_WIDTH-1:0];

    always_comb
    begin
        in_stall  = (state_reg != nha_pkg::ST_IDLE) || clr_busy;
        b_wr_en   = 1'b0;
        b_rd_addr = '0;
        c_rd_addr = caddr_reg;
        c_wr_en   = 1'b0;
        c_wr_data = sum;
        unique case (state_reg)
            nha_pkg::ST_IDLE:
            begin
                b_wr_en = in_xfer && (in_data.mode == nha_pkg::MODE_LOAD) && load_ok;
            end
            nha_pkg::ST_SCAN:
            begin
                b_rd_addr = j_reg + 1'b1;
            end
            nha_pkg::ST_CMOD:
            begin
                if (item_reg.mode == nha_pkg::MODE_FILL)
                begin
                    c_wr_en = 1'b1;
                end
                else if (item_reg.mode == nha_pkg::MODE_CLEAR)
                begin
                    c_wr_en   = 1'b1;
                    c_wr_data = '0;
                end
            end
            default: ;
        endcase
    end

    // datapath
    logic [32:0]   k33;
    logic [BW-1:0] b_fin;
    logic [HW:0]   kbin;
    logic [PW-1:0] pbin;

    assign k33  = 33'(in_data.kappa);
    assign kbin = item_reg.kappa[31] ? (HW+1)'(b_reg) + 1'b1
                                     : (HW+1)'({half, 1'b0}) - (HW+1)'(b_reg);
    assign pbin = (32'(psi_quot) >= 32'(pcount)) ? pcount + 1'b1
                                                 : PW'(psi_quot) + 1'b1;

    always_comb
    begin
        if (found_reg)
        begin
            b_fin = b_reg;
        end
        else if (hit_now)
        begin
            b_fin = j_reg - 1'b1;
        end
        else
        begin
            b_fin = BW'(32'(half) - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            nha_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    item_reg  <= in_data;
                    mag_reg   <= in_data.kappa[31] ? 32'(-k33) : k33[31:0];
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                    caddr_reg <= AW'(in_data.cell_index);
                    // a load finishes here; items that reach the cell store fill the result later
                    res_reg   <= '{accepted: (in_data.mode == nha_pkg::MODE_LOAD) && load_ok,
                                   default: '0};
                end
            end
            nha_pkg::ST_SCAN:
            begin
                prev_reg <= b_rd_data;
                if (j_reg == '0)
                begin
                    b0_reg <= b_rd_data;
                end
                if (scan_last)
                begin
                    b_reg   <= b_fin;
                    rej_reg <= (mag_reg > 32'(b0_reg)) || (mag_reg < 32'(b_rd_data));
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                    if (hit_now && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        b_reg     <= j_reg - 1'b1;
                    end
                end
            end
            nha_pkg::ST_ADDR:
            begin
                caddr_reg <= AW'(32'(pbin) * 32'({half, 1'b0} + 2'd2) + 32'(kbin));
                if (fill_ok)
                begin
                    res_reg.kappa_bin <= 8'(kbin);
                    res_reg.psi_bin   <= 8'(pbin);
                end
            end
            nha_pkg::ST_CMOD:
            begin
                res_reg.accepted     <= 1'b1;
                res_reg.cell_address <= 15'(caddr_reg);
                if (item_reg.mode == nha_pkg::MODE_FILL)
                begin
                    res_reg.content <= 32'($signed(sum));
                end
                else
                begin
                    res_reg.content <= 32'($signed(c_rd_data));
                end
            end
            default: ;
        endcase
    end

    // state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nha_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == nha_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == nha_pkg::ST_DONE && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/nha_bound_mem.sv]
module nha_bound_mem #(
    parameter int DEPTH = nha_pkg::DEF_MAX_KAPPA_HALF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [30:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [30:0]   rd_data
);

    logic [30:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/nha_cell_mem.sv]
module nha_cell_mem #(
    parameter int DEPTH = 16900,
    parameter int DW    = nha_pkg::DEF_COUNT_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          busy
);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] clr_reg, clr_next;
    logic          busy_reg, busy_next;

    // clearing pass after reset, one entry per cycle
    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (32'(clr_reg) == DEPTH - 1)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_next = clr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;

endmodule

[rtl/core/nha_psi_unit.sv]
module nha_psi_unit (
    input  logic               clk,
    input  logic signed [31:0] psi,
    input  logic signed [31:0] psi_min,
    input  logic signed [31:0] psi_max,
    input  logic [31:0]        psi_scale,
    output logic [19:0]        quot,
    output logic               in_range
);

    // offset from psi_min; only meaningful when psi is inside the window,
    // where it fits 32 unsigned bits
    logic [31:0] off;
    logic [63:0] prod;

    assign off  = psi - psi_min;
    assign prod = 64'(off) * 64'(psi_scale);

    always_ff @(posedge clk)
    begin
        quot     <= prod[63:44];
        in_range <= (psi >= psi_min) && (psi <= psi_max);
    end

endmodule

[test/tb_top.sv]
module tb_top;

    localparam int CELLS      = (nha_pkg::DEF_MAX_PSI_BINS + 2)
                                * (2 * nha_pkg::DEF_MAX_KAPPA_HALF + 2);
    localparam int TABLE_SIZE = nha_pkg::DEF_MAX_KAPPA_HALF;
    // clearing pass plus ~2100 items, with stalls, several times over
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        nha_pkg::in_t item;
        bit           drain;     // hold this transfer until every result is back
    } pending_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    nha_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_stall;
    nha_pkg::out_t out_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_data;

    nonuniform_histogram_accumulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block: registers, boundary table and cell store
    logic [6:0]  hist_half;
    logic [7:0]  hist_count;
    logic [31:0] hist_psi_min;
    logic [31:0] hist_psi_max;
    logic [31:0] hist_scale;
    logic [30:0] hist_bounds [TABLE_SIZE];
    logic [31:0] hist_cells [CELLS];

    // boundary table as the stimulus will have left it, tracked at queue-fill time
    logic [30:0] plan_bounds [TABLE_SIZE];

    pending_t      pending_items[$];
    nha_pkg::out_t expected_results[$];

    int send_idle_pct;
    int stall_pct;
    int error_count;
    int cycle_count;
    int fills_binned, fills_rejected, loads_done, reads_done, reads_out_of_range;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_half();
        int unsigned h;
        h = hist_half;
        if (h < 2) h = 2;
        if (h > nha_pkg::DEF_MAX_KAPPA_HALF) h = nha_pkg::DEF_MAX_KAPPA_HALF;
        return h;
    endfunction

    function automatic int unsigned eff_count();
        int unsigned c;
        c = hist_count;
        if (c < 1) c = 1;
        if (c > nha_pkg::DEF_MAX_PSI_BINS) c = nha_pkg::DEF_MAX_PSI_BINS;
        return c;
    endfunction

    // Next histogram result for one accepted transfer; updates the mirror state.
    function automatic nha_pkg::out_t predict_histogram(nha_pkg::in_t it);
        nha_pkg::out_t     r;
        int unsigned       h, cnt, b;
        longint            kap, ps, pmn, pmx, mag;
        longint unsigned   off, pb, slot;
        logic [31:0]       sum;
        r = '0;
        case (it.mode)
            nha_pkg::MODE_FILL:
            begin
                h   = eff_half();
                cnt = eff_count();
                kap = it.kappa;
                ps  = it.psi;
                pmn = $signed(hist_psi_min);
                pmx = $signed(hist_psi_max);
                mag = (kap < 0) ? -kap : kap;
                if (mag <= longint'(hist_bounds[0]) && mag >= longint'(hist_bounds[h - 1])
                    && ps >= pmn && ps <= pmx)
                begin
                    // first bin whose interval (next, this] holds the magnitude;
                    // falls back to the innermost bin (exact match on the last boundary)
                    b = h - 1;
                    for (int i = 0; i + 1 < h; i++)
                    begin
                        if (mag <= longint'(hist_bounds[i])
                            && mag > longint'(hist_bounds[i + 1]))
                        begin
                            b = i;
                            break;
                        end
                    end
                    r.kappa_bin = (kap < 0) ? 8'(b + 1) : 8'(2 * h - b);
                    off = longint'(ps - pmn);
                    pb  = 1 + ((off * longint'(hist_scale)) >> 44);
                    if (pb > cnt + 1) pb = cnt + 1;
                    r.psi_bin = 8'(pb);
                    slot = pb * (2 * h + 2) + r.kappa_bin;
                    sum = hist_cells[slot] + {{16{it.weight[15]}}, it.weight};
                    hist_cells[slot] = sum;
                    r.accepted     = 1'b1;
                    r.cell_address = 15'(slot);
                    r.content      = sum;
                    fills_binned++;
                end
                else
                    fills_rejected++;
            end
            nha_pkg::MODE_LOAD:
            begin
                hist_bounds[it.table_index] = it.table_value;
                r.accepted = 1'b1;
                loads_done++;
            end
            default:
            begin
                if (it.cell_index < CELLS)
                begin
                    r.accepted     = 1'b1;
                    r.cell_address = it.cell_index;
                    r.content      = hist_cells[it.cell_index];
                    if (it.mode == nha_pkg::MODE_CLEAR) hist_cells[it.cell_index] = '0;
                    reads_done++;
                end
                else
                    reads_out_of_range++;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            error_count++;
        end
    endfunction

    // driver: one transfer per accepted item, refilled from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_histogram(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0
                    && (!pending_items[0].drain || expected_results.size() == 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items[0].item;
                    in_valid <= 1'b1;
                    pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                    error_count++;
                end
                else
                begin
                    nha_pkg::out_t e;
                    e = expected_results.pop_front();
                    check_field("accepted", e.accepted, out_data.accepted);
                    check_field("kappa_bin", e.kappa_bin, out_data.kappa_bin);
                    check_field("psi_bin", e.psi_bin, out_data.psi_bin);
                    check_field("cell_address", e.cell_address, out_data.cell_address);
                    check_field("content", e.content, out_data.content);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            nha_pkg::CFG_KAPPA_HALF: hist_half    = val[6:0];
            nha_pkg::CFG_PSI_COUNT:  hist_count   = val[7:0];
            nha_pkg::CFG_PSI_MIN:    hist_psi_min = val;
            nha_pkg::CFG_PSI_MAX:    hist_psi_max = val;
            nha_pkg::CFG_PSI_SCALE:  hist_scale   = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        // margin for a fill, the longest item, to finish its table scan
        repeat (nha_pkg::DEF_MAX_KAPPA_HALF + 16) @(posedge clk);
    endtask

    // New register setting and idle profile. auto_scale spreads the psi range
    // slightly past the last bin so saturation shows up too.
    task automatic set_phase(input logic [6:0] half, input logic [7:0] count,
                             input logic [31:0] pmin, input logic [31:0] pmax,
                             input logic [31:0] scale, input bit auto_scale,
                             input int send_pct, input int stall_p);
        longint          span;
        longint unsigned s;
        wait_idle();
        s = scale;
        span = longint'($signed(pmax)) - longint'($signed(pmin));
        if (auto_scale && span >= 0)
        begin
            s = (longint'(count == 0 ? 1 : count) + 1) * (64'd1 << 44) / (span + 1);
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        end
        write_reg(nha_pkg::CFG_KAPPA_HALF, {25'd0, half});
        write_reg(nha_pkg::CFG_PSI_COUNT, {24'd0, count});
        write_reg(nha_pkg::CFG_PSI_MIN, pmin);
        write_reg(nha_pkg::CFG_PSI_MAX, pmax);
        write_reg(nha_pkg::CFG_PSI_SCALE, s[31:0]);
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
    endtask

    function automatic nha_pkg::in_t mk_fill(logic [31:0] k, logic [31:0] p, logic [15:0] w);
        nha_pkg::in_t it;
        it        = '0;
        it.mode   = nha_pkg::MODE_FILL;
        it.kappa  = k;
        it.psi    = p;
        it.weight = w;
        return it;
    endfunction

    function automatic nha_pkg::in_t mk_cell(logic [1:0] m, int idx);
        nha_pkg::in_t it;
        it            = '0;
        it.mode       = m;
        it.cell_index = 15'(idx);
        return it;
    endfunction

    function automatic nha_pkg::in_t mk_load(int idx, logic [30:0] v);
        nha_pkg::in_t it;
        it             = '0;
        it.mode        = nha_pkg::MODE_LOAD;
        it.table_index = 6'(idx);
        it.table_value = v;
        plan_bounds[idx] = v;
        return it;
    endfunction

    task automatic push(input nha_pkg::in_t it, input bit drain = 1'b0);
        pending_t p;
        p.item  = it;
        p.drain = drain;
        pending_items.push_back(p);
    endtask

    // Mostly fills that land in a real bin, plus reads, clears, boundary rewrites
    // that keep the table descending, and a share of raw noise.
    task automatic add_random(input int n, input int pause_at);
        nha_pkg::in_t    it;
        int unsigned     h, b, sel, idx;
        longint          pmn, pmx, span, mag, ps;
        longint unsigned lo, hi;
        logic [159:0]    raw;
        for (int i = 0; i < n; i++)
        begin
            h   = eff_half();
            pmn = $signed(hist_psi_min);
            pmx = $signed(hist_psi_max);
            span = pmx - pmn;
            sel = $urandom_range(99);
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it  = raw[$bits(nha_pkg::in_t)-1:0];
            if (sel < 65)
            begin
                b = $urandom_range(h - 1);
                if (b == h - 1)
                    mag = plan_bounds[b];
                else
                    mag = longint'(plan_bounds[b + 1]) + 1
                          + ({$urandom, $urandom} % (plan_bounds[b] - plan_bounds[b + 1]));
                case ($urandom_range(9))
                    0:       ps = pmn;
                    1:       ps = pmx;
                    default: ps = (span < 0) ? longint'($signed($urandom))
                                             : pmn + longint'({$urandom, $urandom} % (span + 1));
                endcase
                it = mk_fill($urandom_range(1) ? 32'(-mag) : 32'(mag), 32'(ps), 16'($urandom));
            end
            else if (sel < 80)
            begin
                it = mk_cell(sel < 72 ? nha_pkg::MODE_READ : nha_pkg::MODE_CLEAR,
                             $urandom_range(9) == 0 ? $urandom_range(32767)
                                                    : $urandom_range(CELLS - 1));
            end
            else if (sel < 85)
            begin
                idx = $urandom_range(TABLE_SIZE - 1);
                hi = (idx == 0) ? 64'h7FFF_FFFF : longint'(plan_bounds[idx - 1]) - 1;
                lo = (idx == TABLE_SIZE - 1) ? 1 : longint'(plan_bounds[idx + 1]) + 1;
                if (hi >= lo)
                    it = mk_load(idx, 31'(lo + {$urandom, $urandom} % (hi - lo + 1)));
                else
                    it = mk_load(idx, plan_bounds[idx]);
            end
            else if (it.mode == nha_pkg::MODE_LOAD)
            begin
                // raw boundary writes would break the table order
                it.mode = nha_pkg::MODE_READ;
            end
            push(it, i == pause_at);
        end
    endtask

    initial
    begin
        longint unsigned v;
        rst_n     = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        error_count   = 0;
        cycle_count   = 0;
        fills_binned = 0; fills_rejected = 0; loads_done = 0;
        reads_done = 0; reads_out_of_range = 0;
        hist_half    = nha_pkg::RST_KAPPA_HALF;
        hist_count   = nha_pkg::RST_PSI_COUNT;
        hist_psi_min = '0;
        hist_psi_max = '0;
        hist_scale   = '0;
        foreach (hist_cells[i]) hist_cells[i] = '0;
        foreach (hist_bounds[i]) hist_bounds[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // full range defaults: 64 half bins, 128 psi bins over +-4 rad
        set_phase(7'd64, 8'd128, 32'hC000_0000, 32'h4000_0000, 32'd0, 1'b1, 0, 0);

        // boundary table, strictly descending, top entry at full scale
        // every entry is written before the first fill can read it
        v = 64'h7FFF_FFFF;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (i > 0) v = v - $urandom_range(1, 32'(v / (70 - i)));
            push(mk_load(i, 31'(v)));
        end

        // edges of both axes, the repaired innermost-bin match, weight extremes
        push(mk_fill({1'b0, plan_bounds[0]}, hist_psi_min, 16'sh7FFF));
        push(mk_fill(-{1'b0, plan_bounds[0]}, hist_psi_max, 16'sh8000));
        push(mk_fill({1'b0, plan_bounds[63]}, 32'd0, 16'd1));
        push(mk_fill(-{1'b0, plan_bounds[63]}, 32'd0, 16'hFFFF));
        push(mk_fill({1'b0, plan_bounds[63]} - 1, 32'd0, 16'd5));
        push(mk_fill(32'h8000_0000, 32'd0, 16'd5));
        push(mk_fill(32'h7FFF_FFFF, 32'd0, 16'd7));
        push(mk_fill(32'd0, 32'd0, 16'd7));
        push(mk_fill({1'b0, plan_bounds[10]}, hist_psi_min - 1, 16'd3));
        push(mk_fill({1'b0, plan_bounds[10]}, hist_psi_max + 1, 16'd3));
        push(mk_fill({1'b0, plan_bounds[10]}, 32'h0123_4567, 16'd3));
        // top-bin cell of the first psi row: read, clear, read back
        push(mk_cell(nha_pkg::MODE_READ, 258));
        push(mk_cell(nha_pkg::MODE_CLEAR, 258));
        push(mk_cell(nha_pkg::MODE_READ, 258));
        push(mk_cell(nha_pkg::MODE_READ, 0));
        push(mk_cell(nha_pkg::MODE_READ, CELLS - 1));
        push(mk_cell(nha_pkg::MODE_CLEAR, CELLS));
        push(mk_cell(nha_pkg::MODE_READ, 32767));
        push(mk_load(63, plan_bounds[63]));
        add_random(300, -1);

        // narrowest kappa axis, one psi bin, widest psi range, saturating scale
        set_phase(7'd2, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 61, 0);
        add_random(330, -1);

        // out-of-range register values clamp; receiver stalls often
        set_phase(7'd127, 8'd255, 32'hFFFF_FF9C, 32'h7FFF_FFFF, 32'd0, 1'b1, 0, 61);
        add_random(330, -1);

        // mid sizes, no idling, one full drain in the middle
        set_phase(7'd17, 8'd40, 32'd0, 32'h1000_0000, 32'd0, 1'b1, 0, 0);
        add_random(330, 160);

        // half below range, zero count, empty psi window: every fill rejected
        set_phase(7'd1, 8'd0, 32'd1000, 32'hFFFF_FC18, 32'd0, 1'b0, 15, 15);
        add_random(200, -1);

        // fixed asymmetric window, zero scale keeps every fill in the first psi bin
        set_phase(7'd64, 8'd128, 32'hF000_0000, 32'h0800_0000, 32'd0, 1'b0, 61, 61);
        add_random(150, -1);

        set_phase(7'd33, 8'd77, $urandom & 32'h8FFF_FFFF, 32'h7000_0000, 32'd0, 1'b1, 15, 15);
        add_random(330, -1);

        wait_idle();
        $display("fills binned %0d, rejected %0d; boundary loads %0d",
                 fills_binned, fills_rejected, loads_done);
        $display("cell reads %0d, out-of-range reads %0d, over %0d cycles",
                 reads_done, reads_out_of_range, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[nonuniform_histogram_accumulator_unit.f]
rtl/core/nha_pkg.sv
rtl/core/nha_bound_mem.sv
rtl/core/nha_cell_mem.sv
rtl/core/nha_psi_unit.sv
rtl/core/nonuniform_histogram_accumulator_unit.sv
test/tb_top.sv
